/* rtl/mbpm_pkg.sv */
// Shared constants, codes and types of the mask boundary pixel marker.
package mbpm_pkg;

  // Largest frame width that the line store holds.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Column index, width register and start-up count widths follow MAX_WIDTH.
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W = $clog2(2 * MAX_WIDTH + 3);

  // Fixed field and register widths.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned HGT_W     = 11;
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned PIX_W     = 10;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // Reset sizes, already clamped to the supported range.
  localparam int unsigned WIDTH_RESET  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned HEIGHT_RESET = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Input item kinds.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  // One line store entry, kept at the column of the current pixel.
  typedef struct packed {
    logic edge_up2;  // edge mark three rows and one column back
    logic edge_up1;  // edge mark two rows and one column back
    logic mask_up2;  // mask bit two rows back
    logic mask_up1;  // mask bit one row back
  } line_t;

endpackage

/* rtl/mask_boundary_pixel_marker.sv */
// Top level: streaming 4-neighbour boundary and corner marker for a binary mask.
//
//  Channel   | Direction | Payload                                   | Handshake
//  ----------+-----------+-------------------------------------------+-----------------------
//  s_axis    | in        | tdata[0] in_mask, tuser kind              | tvalid / tready
//  m_axis    | out       | tdata row, col, edge, corner; tlast last  | tvalid / tready
//  cfg       | in        | cfg_index_i, cfg_data_i                   | cfg_valid_i/cfg_ready_o
//
// One pixel transfer is taken every clock cycle unless stalled; the result for a
// pixel leaves 2*W+2 transfers later through a single output register. The per-item
// path is one line store read (registered in advance) feeding the mask and edge
// windows and the result register. The line store is never cleared: entries
// from an earlier frame are only read where the border rules make them moot.
// Input is stalled only while the output register holds a result not taken.
module mask_boundary_pixel_marker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Pixel stream in.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mbpm_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [0] in_mask, rest zero
  input  logic                                s_axis_tuser,   // [0] kind
  // Result stream out.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mbpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [9:0] pixel_row,
                                                              // [19:10] pixel_col,
                                                              // [20] edge_mark,
                                                              // [21] corner_mark, rest zero
  output logic                                m_axis_tlast,   // frame_last
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbpm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mbpm_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned ColW = mbpm_pkg::COL_W;
  localparam int unsigned WidW = mbpm_pkg::WID_W;
  localparam int unsigned CntW = mbpm_pkg::CNT_W;
  localparam int unsigned HgtW = mbpm_pkg::HGT_W;
  localparam int unsigned RowW = mbpm_pkg::ROW_W;
  localparam int unsigned PixW = mbpm_pkg::PIX_W;

  // Size registers, held already clamped.
  logic [WidW-1:0] width_q;
  logic [HgtW-1:0] height_q;

  // Input position and start-up count.
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Position of the pixel described by the next result.
  logic [ColW-1:0] out_col_q, out_col_d;
  logic [PixW-1:0] out_row_q, out_row_d;

  // Mask window: column 0 holds the previous pixel and the two above it,
  // column 1 the middle and top rows one pixel further back.
  logic [2:0] mcol0_q;
  logic [1:0] mcol1_q;
  // Edge window: two columns of three rows, newest row at index 0.
  logic [2:0] ecol0_q;
  logic [2:0] ecol1_q;

  // Line store.
  mbpm_pkg::line_t line_mem [mbpm_pkg::MAX_WIDTH];
  mbpm_pkg::line_t line_rd_q;
  mbpm_pkg::line_t line_wr;

  // Result register.
  logic            out_valid_q;
  logic [PixW-1:0] res_row_q;
  logic [PixW-1:0] res_col_q;
  logic            res_edge_q;
  logic            res_corner_q;
  logic            res_last_q;

  logic            accept;
  logic            emit;
  logic            last_pix;
  logic            restart;
  logic            cfg_restart;
  logic            pix_mask;
  logic [CntW-1:0] delay;
  logic [RowW-1:0] q_row;
  logic            q_border;
  logic            edge_new;
  logic            mask_n;
  logic            edge_n;
  logic            corner_n;

  // Handshakes.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_restart   = cfg_valid_i &&
                         ((cfg_index_i == mbpm_pkg::REG_FRAME_WIDTH) ||
                          (cfg_index_i == mbpm_pkg::REG_FRAME_HEIGHT));

  // Configuration registers, clamped to their supported range on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidW'(mbpm_pkg::WIDTH_RESET);
      height_q <= HgtW'(mbpm_pkg::HEIGHT_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbpm_pkg::REG_FRAME_WIDTH: begin
          if (cfg_data_i == '0) begin
            width_q <= WidW'(1);
          end else if (int'(cfg_data_i) > mbpm_pkg::MAX_WIDTH) begin
            width_q <= WidW'(mbpm_pkg::MAX_WIDTH);
          end else begin
            width_q <= WidW'(cfg_data_i);
          end
        end
        mbpm_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_data_i == '0) begin
            height_q <= HgtW'(1);
          end else if (int'(cfg_data_i) > mbpm_pkg::MAX_HEIGHT) begin
            height_q <= HgtW'(mbpm_pkg::MAX_HEIGHT);
          end else begin
            height_q <= HgtW'(cfg_data_i);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The mask bit entering the window; anything outside the frame is outside the mask.
  assign pix_mask = (in_row_q < RowW'(height_q)) &&
                    (mbpm_pkg::kind_e'(s_axis_tuser) == mbpm_pkg::KIND_PIXEL) &&
                    s_axis_tdata[0];

  // Results start once 2*W+2 pixels of the frame have gone in.
  assign delay    = (CntW'(width_q) << 1) + CntW'(2);
  assign emit     = accept && (cnt_q == delay);
  assign last_pix = ({1'b0, out_row_q} == (height_q - HgtW'(1))) &&
                    (WidW'(out_col_q) == (width_q - WidW'(1)));
  assign restart  = cfg_restart || (emit && last_pix);

  // Position counters.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    cnt_d     = cnt_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept) begin
      if (WidW'(in_col_q) == (width_q - WidW'(1))) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (cnt_q != delay) begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (emit) begin
        if (WidW'(out_col_q) == (width_q - WidW'(1))) begin
          out_col_d = '0;
          out_row_d = out_row_q + PixW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      cnt_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      cnt_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      cnt_q     <= cnt_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Edge mark of the pixel one row and one column behind the current one.
  // Its column is on the border exactly when the current column is 0 or 1.
  assign q_row    = in_row_q - RowW'(1) - RowW'(in_col_q == '0);
  assign q_border = (in_col_q <= ColW'(1)) || (q_row == '0) ||
                    (q_row == (RowW'(height_q) - RowW'(1)));
  assign edge_new = mcol0_q[1] &&
                    (q_border ||
                     !(mcol0_q[2] && mcol0_q[0] && mcol1_q[0] && line_rd_q.mask_up1));

  // Corner test on the pixel two rows and two columns back, from the edge window
  // as it stands after this transfer.
  assign mask_n   = mcol1_q[1];
  assign edge_n   = ecol0_q[1];
  assign corner_n = mask_n && !edge_n &&
                    ((ecol0_q[2] && line_rd_q.edge_up1 && !line_rd_q.edge_up2) ||
                     (line_rd_q.edge_up1 && ecol0_q[0] && !edge_new) ||
                     (ecol0_q[0] && ecol1_q[1] && !ecol1_q[0]) ||
                     (ecol1_q[1] && ecol0_q[2] && !ecol1_q[2]));

  // Windows shift by one column on every pixel transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcol0_q <= '0;
      mcol1_q <= '0;
      ecol0_q <= '0;
      ecol1_q <= '0;
    end else if (accept) begin
      mcol0_q <= {line_rd_q.mask_up2, line_rd_q.mask_up1, pix_mask};
      mcol1_q <= {mcol0_q[2], mcol0_q[1]};
      ecol0_q <= {line_rd_q.edge_up2, line_rd_q.edge_up1, edge_new};
      ecol1_q <= ecol0_q;
    end
  end

  // Line store: written at the current column, read ahead at the next one.
  always_comb begin
    line_wr.mask_up1 = pix_mask;
    line_wr.mask_up2 = line_rd_q.mask_up1;
    line_wr.edge_up1 = edge_new;
    line_wr.edge_up2 = line_rd_q.edge_up1;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[in_col_q] <= line_wr;
    end
    if (accept && (in_col_d == in_col_q)) begin
      line_rd_q <= line_wr;
    end else begin
      line_rd_q <= line_mem[in_col_d];
    end
  end

  // Result register: loads on a transfer that yields a result, empties when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_row_q    <= out_row_q;
      res_col_q    <= PixW'(out_col_q);
      res_edge_q   <= edge_n;
      res_corner_q <= corner_n;
      res_last_q   <= last_pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_last_q;
  assign m_axis_tdata  = {2'b00, res_corner_q, res_edge_q, res_col_q, res_row_q};

  // The input column always stays inside the row in use.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WidW'(in_col_q) < width_q)
    else $error("input column beyond frame width");

  // The described row never passes the last row of the frame.
  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_row_q} < height_q)
    else $error("result row beyond frame height");

  // The final result of a frame returns the position to the frame start.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_pix) |=> (in_col_q == '0) && (in_row_q == '0) && (cnt_q == '0))
    else $error("frame did not restart after its last pixel");

  // A result marked last describes the last column of the row.
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (WidW'(m_axis_tdata[19:10]) == (width_q - WidW'(1))))
    else $error("frame_last on a pixel that is not at the end of its row");

  // A pixel never carries both marks.
  a_marks_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[20] && m_axis_tdata[21]))
    else $error("edge and corner marks set together");

endmodule

/* test/tb.sv */
// Testbench for the mask boundary pixel marker: directed frames, size extremes and random masks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // History depth of the mask predictor, deep enough for four rows and a margin.
  localparam int unsigned HIST_LEN = 4 * mbpm_pkg::MAX_WIDTH + 8;
  // Register indexes that the block does not decode.
  localparam logic [mbpm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [mbpm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  // Cycles to let the pipeline empty before a register write.
  localparam int unsigned SETTLE_CYCLES = 16;

  // Expected marks of one pixel.
  typedef struct packed {
    logic [mbpm_pkg::PIX_W-1:0] pixel_row;
    logic [mbpm_pkg::PIX_W-1:0] pixel_col;
    logic                       edge_mark;
    logic                       corner_mark;
    logic                       frame_last;
  } pixel_marks_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mbpm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mbpm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [mbpm_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mbpm_pkg::CFG_W-1:0]      cfg_data_i = '0;

  mask_boundary_pixel_marker u_top (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: sizes, raster position and mask history.
  logic [mbpm_pkg::CFG_W-1:0] width_reg = 11'd1024;
  logic [mbpm_pkg::CFG_W-1:0] height_reg = 11'd1024;
  int unsigned      row_at = 0;
  int unsigned      col_at = 0;
  bit               mask_hist [HIST_LEN];
  pixel_marks_t     pending_marks [$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_id = 0;
  int unsigned mismatch_count = 0;

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > mbpm_pkg::MAX_WIDTH) return mbpm_pkg::MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > mbpm_pkg::MAX_HEIGHT) return mbpm_pkg::MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  function automatic bit mask_bit(int unsigned r, int unsigned c, int unsigned w);
    return mask_hist[(r * w + c) % HIST_LEN];
  endfunction

  // First pass: a mask pixel on the border or beside an outside pixel.
  function automatic bit edge_bit(int unsigned r, int unsigned c, int unsigned w,
                                  int unsigned h);
    if (!mask_bit(r, c, w)) return 1'b0;
    if (r == 0 || c == 0 || r == h - 1 || c == w - 1) return 1'b1;
    return !(mask_bit(r - 1, c, w) && mask_bit(r + 1, c, w) &&
             mask_bit(r, c - 1, w) && mask_bit(r, c + 1, w));
  endfunction

  // Second pass, for interior mask pixels only: two adjacent edge neighbours
  // around a diagonal that is not an edge.
  function automatic bit corner_bit(int unsigned r, int unsigned c, int unsigned w,
                                    int unsigned h);
    bit up, dn, lf, rt;
    up = edge_bit(r - 1, c, w, h);
    dn = edge_bit(r + 1, c, w, h);
    lf = edge_bit(r, c - 1, w, h);
    rt = edge_bit(r, c + 1, w, h);
    return (up && rt && !edge_bit(r - 1, c + 1, w, h)) ||
           (rt && dn && !edge_bit(r + 1, c + 1, w, h)) ||
           (dn && lf && !edge_bit(r + 1, c - 1, w, h)) ||
           (lf && up && !edge_bit(r - 1, c - 1, w, h));
  endfunction

  // Advance the predictor by one accepted item and queue the marks it releases.
  function automatic void predict_marks(mbpm_pkg::kind_e kind, logic in_mask);
    int unsigned  w, h, lag, pos, n;
    pixel_marks_t marks;
    w = used_width();
    h = used_height();
    lag = 2 * w + 2;
    pos = row_at * w + col_at;
    mask_hist[pos % HIST_LEN] = (row_at < h) && (kind == mbpm_pkg::KIND_PIXEL) && in_mask;
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
    end
    if (pos >= lag) begin
      n = pos - lag;
      marks.pixel_row = mbpm_pkg::PIX_W'(n / w);
      marks.pixel_col = mbpm_pkg::PIX_W'(n % w);
      marks.edge_mark = edge_bit(n / w, n % w, w, h);
      marks.corner_mark = !marks.edge_mark && mask_bit(n / w, n % w, w) &&
                          corner_bit(n / w, n % w, w, h);
      marks.frame_last = (n == w * h - 1);
      pending_marks.insert(pending_marks.size(), marks);
      if (marks.frame_last) begin
        row_at = 0;
        col_at = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Result checker: every result transfer is matched against the oldest expectation.
  pixel_marks_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_marks.size() == 0) begin
        report_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                  m_axis_tdata[9:0], m_axis_tdata[19:10]));
      end else begin
        want = pending_marks.pop_front();
        if (m_axis_tdata[9:0] !== want.pixel_row)
          report_mismatch($sformatf("pixel_row %0d, expected %0d",
                                    m_axis_tdata[9:0], want.pixel_row));
        if (m_axis_tdata[19:10] !== want.pixel_col)
          report_mismatch($sformatf("pixel_col %0d, expected %0d",
                                    m_axis_tdata[19:10], want.pixel_col));
        if (m_axis_tdata[20] !== want.edge_mark)
          report_mismatch($sformatf("edge_mark %b at (%0d,%0d), expected %b", m_axis_tdata[20],
                                    want.pixel_row, want.pixel_col, want.edge_mark));
        if (m_axis_tdata[21] !== want.corner_mark)
          report_mismatch($sformatf("corner_mark %b at (%0d,%0d), expected %b",
                                    m_axis_tdata[21], want.pixel_row, want.pixel_col,
                                    want.corner_mark));
        if (m_axis_tlast !== want.frame_last)
          report_mismatch($sformatf("frame_last %b at (%0d,%0d), expected %b", m_axis_tlast,
                                    want.pixel_row, want.pixel_col, want.frame_last));
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs requested by the tests.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Offer one item, with random gaps before it, and predict once it is taken.
  task automatic push_pixel(input mbpm_pkg::kind_e kind, input logic in_mask);
    @(negedge clk_i);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {{(mbpm_pkg::IN_DATA_W-1){1'b0}}, in_mask};
    s_axis_tuser = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_marks(kind, in_mask);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_marks.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only once the block has gone quiet.
  task automatic write_reg(input logic [mbpm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    settle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value[mbpm_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mbpm_pkg::REG_FRAME_WIDTH) begin
      width_reg = value[mbpm_pkg::CFG_W-1:0];
      row_at = 0;
      col_at = 0;
    end else if (idx == mbpm_pkg::REG_FRAME_HEIGHT) begin
      height_reg = value[mbpm_pkg::CFG_W-1:0];
      row_at = 0;
      col_at = 0;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_gaps(input int unsigned send_pct, input int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
  endtask

  // Stream a w x h frame of random mask bits and its flush tail. Stray flush
  // items land inside the frame, the tail mixes both kinds. The frame can be
  // cut after stop_after items, and the sender can wait for all results
  // before item pause_at.
  task automatic stream_frame(input int unsigned w, input int unsigned h,
                              input int unsigned fill_pct, input int unsigned noise_pct,
                              input int unsigned stop_after, input int pause_at);
    for (int unsigned i = 0; i < stop_after; i++) begin
      if (pause_at > 0 && i == pause_at) drain_results();
      if (i >= w * h) begin
        push_pixel(mbpm_pkg::kind_e'($urandom_range(1)), 1'($urandom_range(1)));
      end else if ($urandom_range(99) < noise_pct) begin
        push_pixel(mbpm_pkg::KIND_FLUSH, 1'($urandom_range(1)));
      end else begin
        push_pixel(mbpm_pkg::KIND_PIXEL, $urandom_range(99) < fill_pct);
      end
    end
  endtask

  // Reset sizes: the start of a full-size frame stays silent.
  task automatic test_reset_sizes();
    stream_frame(mbpm_pkg::WIDTH_RESET, mbpm_pkg::HEIGHT_RESET, 80, 5, 40, -1);
  endtask

  // One-pixel frames from zero sizes, a restart by register write and pixel
  // items after the frame treated as outside.
  task automatic test_tiny_frame();
    write_reg(mbpm_pkg::REG_FRAME_WIDTH, 0);
    write_reg(mbpm_pkg::REG_FRAME_HEIGHT, 0);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b0);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b1);
    write_reg(mbpm_pkg::REG_FRAME_HEIGHT, 0);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b0);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b1);
  endtask

  // 3x3 frame whose top right pixel is a flush item, so the center closes a
  // corner. Writes to undecoded indexes in mid-frame must not restart it.
  task automatic test_corner_close();
    write_reg(mbpm_pkg::REG_FRAME_WIDTH, 3);
    write_reg(mbpm_pkg::REG_FRAME_HEIGHT, 3);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    write_reg(REG_SPARE_2, 1);
    write_reg(REG_SPARE_3, 2047);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b1);
    repeat (6) push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b0);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b0);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b1);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b1);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b0);
    push_pixel(mbpm_pkg::KIND_PIXEL, 1'b0);
    push_pixel(mbpm_pkg::KIND_FLUSH, 1'b1);
  endtask

  // Widest frame: an oversized width saturates to the line store size, so the
  // start of the frame stays silent.
  task automatic test_widest_frame();
    write_reg(mbpm_pkg::REG_FRAME_WIDTH, 2047);
    write_reg(mbpm_pkg::REG_FRAME_HEIGHT, 2);
    stream_frame(mbpm_pkg::MAX_WIDTH, 2, 80, 2, 40, -1);
  endtask

  // Tall frame: an oversized height saturates, so none of the first rows is
  // taken as the last one.
  task automatic test_tallest_frame();
    write_reg(mbpm_pkg::REG_FRAME_WIDTH, 3);
    write_reg(mbpm_pkg::REG_FRAME_HEIGHT, 2047);
    stream_frame(3, mbpm_pkg::MAX_HEIGHT, 85, 2, 248, -1);
  endtask

  // Random frames, mostly small and complete, some cut short, with one long
  // receiver hold-off while a full frame keeps coming.
  task automatic test_random_frames(input int unsigned budget);
    int unsigned sent, w, h, fill, total, stop;
    int          pause;
    bit          must_write, held, hold_now;
    sent = 0;
    must_write = 1'b1;
    held = 1'b0;
    w = 1;
    h = 1;
    while (sent < budget) begin
      hold_now = !held && (sent > budget / 3);
      if (must_write || hold_now || $urandom_range(3) != 0) begin
        if (hold_now) begin
          w = $urandom_range(4, 10);
          h = $urandom_range(2, 8);
        end else if ($urandom_range(5) == 0) begin
          w = $urandom_range(13, 48);
          h = $urandom_range(1, 4);
        end else begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 8);
        end
        write_reg(mbpm_pkg::REG_FRAME_WIDTH, (w == 1 && $urandom_range(1)) ? 0 : w);
        write_reg(mbpm_pkg::REG_FRAME_HEIGHT, (h == 1 && $urandom_range(1)) ? 0 : h);
      end
      case ($urandom_range(2))
        0: fill = 50;
        1: fill = 80;
        default: fill = 95;
      endcase
      total = w * h + 2 * w + 2;
      stop = ($urandom_range(7) == 0) ? $urandom_range(1, total - 1) : total;
      must_write = (stop != total);
      pause = ($urandom_range(3) == 0) ? int'($urandom_range(stop)) : -1;
      if (hold_now) begin
        hold_len = 300;
        hold_id++;
        held = 1'b1;
        stop = total;
        must_write = 1'b0;
        pause = -1;
      end
      stream_frame(w, h, fill, $urandom_range(8), stop, pause);
      sent += stop;
    end
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    set_gaps(38, 53);
    test_reset_sizes();
    test_tiny_frame();
    test_corner_close();
    test_widest_frame();
    set_gaps(53, 38);
    test_tallest_frame();
    test_random_frames(340);
    set_gaps(0, 0);
    test_random_frames(340);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
